>>> hw/rtl/ordered_list_table_top_defines.svh
// Assertion macros for the ordered list table.
`ifndef ORDERED_LIST_TABLE_TOP_DEFINES_SVH
`define ORDERED_LIST_TABLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define OLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define OLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define OLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/olt_pkg.sv
// Shared types, codes and command/status structs of the ordered list table.
package olt_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int KIND_W    = 2;
    localparam int VAL_W     = 32;
    localparam int STS_W     = 3;

    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [STS_W-1:0]  t_status;

    localparam t_kind KIND_INSERT  = 2'd0;
    localparam t_kind KIND_DELETE  = 2'd1;
    localparam t_kind KIND_DISPLAY = 2'd2;

    localparam t_status ST_INSERTED = 3'd0;
    localparam t_status ST_DELETED  = 3'd1;
    localparam t_status ST_MISSING  = 3'd2;
    localparam t_status ST_EMPTY    = 3'd3;
    localparam t_status ST_FULL     = 3'd4;
    localparam t_status ST_ENTRY    = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;        // capture the input value
        logic    idx_clr;
        logic    idx_inc;
        logic    rd_en;       // read the table
        logic    rd_next;     // read at index plus one
        logic    wr_en;
        logic    wr_tail;     // write input value at the tail, else move read data
        logic    count_inc;
        logic    count_dec;
        logic    status_ld;
        t_status status;
        logic    emit;        // load the result register
        logic    emit_entry;  // result is a listed entry
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic idx_last;
        logic match;
        logic out_free;
    } t_sts;

endpackage

>>> hw/rtl/olt_if.sv
// Valid/ready channel interfaces for operation items and result items.
interface olt_in_if;
    logic                            valid;
    logic                            ready;
    logic [olt_pkg::KIND_W-1:0]      kind;
    logic signed [olt_pkg::VAL_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface olt_out_if;
    logic                             valid;
    logic                             ready;
    logic [olt_pkg::STS_W-1:0]        status;
    logic signed [olt_pkg::VAL_W-1:0] entry_value;
    logic                             last;

    modport source (output valid, output status, output entry_value, output last,
                    input ready);
    modport sink   (input valid, input status, input entry_value, input last,
                    output ready);
endinterface

>>> hw/rtl/olt_datapath.sv
// Table memory, count, index, captured value and result register.
module olt_datapath #(
    parameter int DEPTH = olt_pkg::DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  olt_pkg::t_cmd                    i_cmd,
    input  logic signed [olt_pkg::VAL_W-1:0] i_value,
    input  logic                             i_out_ready,
    output olt_pkg::t_sts                    o_sts,
    output logic [$clog2(DEPTH+1)-1:0]       o_count,
    output logic                             o_out_valid,
    output logic [olt_pkg::STS_W-1:0]        o_status,
    output logic signed [olt_pkg::VAL_W-1:0] o_entry_value,
    output logic                             o_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic signed [olt_pkg::VAL_W-1:0] r_mem [DEPTH];

    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    r_idx;
    logic signed [olt_pkg::VAL_W-1:0] r_value;
    logic signed [olt_pkg::VAL_W-1:0] r_rdata;
    olt_pkg::t_status                 r_status;
    logic                             r_out_valid;
    olt_pkg::t_status                 r_out_status;
    logic signed [olt_pkg::VAL_W-1:0] r_out_entry;
    logic                             r_out_last;

    logic [CW-1:0] idx_p1;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          idx_last;

    assign idx_p1   = r_idx + CW'(1);
    assign idx_last = (idx_p1 >= r_count);
    assign rd_addr  = i_cmd.rd_next ? idx_p1[AW-1:0] : r_idx[AW-1:0];
    assign wr_addr  = i_cmd.wr_tail ? r_count[AW-1:0] : r_idx[AW-1:0];

    // Table storage: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= i_cmd.wr_tail ? r_value : r_rdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
        end
        if (i_cmd.status_ld) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_entry ? olt_pkg::ST_ENTRY : r_status;
            r_out_entry  <= i_cmd.emit_entry ? r_rdata : '0;
            r_out_last   <= i_cmd.emit_entry ? idx_last : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.count_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= idx_p1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.count_full = (r_count == DEPTH_C);
    assign o_sts.idx_last   = idx_last;
    assign o_sts.match      = (r_rdata == r_value);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_count       = r_count;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_entry_value = r_out_entry;
    assign o_last        = r_out_last;

endmodule

>>> hw/rtl/olt_ctrl.sv
// Sequencer for insert, search-and-compact delete and display walks.
module olt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [olt_pkg::KIND_W-1:0] i_kind,
    input  olt_pkg::t_sts              i_sts,
    output logic                       o_in_ready,
    output olt_pkg::t_cmd              o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_INS   = 9'b000000010,
        S_SREAD = 9'b000000100,
        S_SCMP  = 9'b000001000,
        S_CWR   = 9'b000010000,
        S_CCHK  = 9'b000100000,
        S_DREAD = 9'b001000000,
        S_DOUT  = 9'b010000000,
        S_RESP  = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    case (i_kind)
                        olt_pkg::KIND_INSERT: begin
                            if (i_sts.count_full) begin
                                o_cmd.status_ld = 1'b1;
                                o_cmd.status    = olt_pkg::ST_FULL;
                                n_state         = S_RESP;
                            end else begin
                                n_state = S_INS;
                            end
                        end
                        olt_pkg::KIND_DELETE: begin
                            if (i_sts.count_zero) begin
                                o_cmd.status_ld = 1'b1;
                                o_cmd.status    = olt_pkg::ST_EMPTY;
                                n_state         = S_RESP;
                            end else begin
                                n_state = S_SREAD;
                            end
                        end
                        olt_pkg::KIND_DISPLAY: begin
                            if (i_sts.count_zero) begin
                                o_cmd.status_ld = 1'b1;
                                o_cmd.status    = olt_pkg::ST_EMPTY;
                                n_state         = S_RESP;
                            end else begin
                                n_state = S_DREAD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_tail   = 1'b1;
                o_cmd.count_inc = 1'b1;
                o_cmd.status_ld = 1'b1;
                o_cmd.status    = olt_pkg::ST_INSERTED;
                n_state         = S_RESP;
            end
            S_SREAD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SCMP;
            end
            S_SCMP: begin
                // Fetch the following entry every cycle: it is either the next
                // candidate or the first entry to move down.
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_next = 1'b1;
                if (i_sts.match) begin
                    if (i_sts.idx_last) begin
                        o_cmd.count_dec = 1'b1;
                        o_cmd.status_ld = 1'b1;
                        o_cmd.status    = olt_pkg::ST_DELETED;
                        n_state         = S_RESP;
                    end else begin
                        n_state = S_CWR;
                    end
                end else if (i_sts.idx_last) begin
                    o_cmd.status_ld = 1'b1;
                    o_cmd.status    = olt_pkg::ST_MISSING;
                    n_state         = S_RESP;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_CWR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                n_state       = S_CCHK;
            end
            S_CCHK: begin
                if (i_sts.idx_last) begin
                    o_cmd.count_dec = 1'b1;
                    o_cmd.status_ld = 1'b1;
                    o_cmd.status    = olt_pkg::ST_DELETED;
                    n_state         = S_RESP;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_CWR;
                end
            end
            S_DREAD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_DOUT;
            end
            S_DOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_entry = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_DREAD;
                    end
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/ordered_list_table_top.sv
// Top level of the ordered list table: controller, datapath and checks.
//
//  channel | dir | fields                        | handshake
//  --------+-----+-------------------------------+-------------------------
//  i_in    | in  | kind[1:0], value[31:0] s      | valid/ready, one op
//  o_out   | out | status[2:0], entry_value s,   | valid/ready, one result
//          |     | last                          |
//
// One item is worked at a time. Insert writes the value at the tail and answers
// inserted; an insert into a full list or a delete or display on an empty one gets
// a plain full or empty result; delete compares entry by entry from the head, then
// moves each later entry down by one, lowers the count and answers deleted, or else
// answers missing; display gives one entry result per entry, the last one flagged;
// an unused code is taken and gives no result. The table is read with registered
// data, and there is one result register. Reset clears the count, the index and
// the result flag; the table is never cleared. A stalled result holds the sequencer.
`include "ordered_list_table_top_defines.svh"

module ordered_list_table_top #(
    parameter int DEPTH = olt_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    olt_in_if.sink     i_in,
    olt_out_if.source  o_out
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    olt_pkg::t_cmd cmd;
    olt_pkg::t_sts dp_sts;
    logic [CW-1:0] dp_count;

    // Sequence each operation; take a new item only when idle.
    olt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_kind     (i_in.kind),
        .i_sts      (dp_sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    // Hold the table, the count and the result register.
    olt_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_value       (i_in.value),
        .i_out_ready   (o_out.ready),
        .o_sts         (dp_sts),
        .o_count       (dp_count),
        .o_out_valid   (o_out.valid),
        .o_status      (o_out.status),
        .o_entry_value (o_out.entry_value),
        .o_last        (o_out.last)
    );

    // Checks: count bound, shape of plain results, count held on an insert into a full list.
    logic full_insert;
    logic plain_out;
    logic plain_ok;

    assign full_insert = i_in.valid && i_in.ready && (i_in.kind == olt_pkg::KIND_INSERT)
                         && dp_sts.count_full;
    assign plain_out   = o_out.valid && (o_out.status != olt_pkg::ST_ENTRY);
    assign plain_ok    = (o_out.entry_value == '0) && o_out.last;

    `OLT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, dp_count <= DEPTH_C, "count beyond depth")
    `OLT_ASSERT_NOW(a_plain_result, i_clk, i_rst_n, plain_out, plain_ok, "bad plain result")
    `OLT_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, full_insert, $stable(dp_count), "full insert moved count")

endmodule
